// ===== rtl/rfc_pkg.sv =====
package rfc_pkg;

  // field sizes, defaults for the top-level parameters
  localparam int RFC_LENGTH_BYTES_DEF = 8;
  localparam int RFC_CHECKSUM_BYTES_DEF = 8;
  localparam int RFC_HEADER_BYTES_DEF = 4;
  localparam int RFC_COUNT_BYTES = 4;

  localparam logic [15:0] RFC_MIN_BYTES_RST = 16'd100;
  localparam logic [31:0] RFC_CRC_POLY = 32'hEDB8_8320;

  localparam int RFC_PASSED_W = 31;
  localparam int RFC_VERDICT_W = 2;
  localparam int RFC_PHASE_W = 3;

  // parse phases
  localparam logic [RFC_PHASE_W-1:0] PH_HEADER = 3'd0;
  localparam logic [RFC_PHASE_W-1:0] PH_COUNT = 3'd1;
  localparam logic [RFC_PHASE_W-1:0] PH_LENGTH = 3'd2;
  localparam logic [RFC_PHASE_W-1:0] PH_DATA = 3'd3;
  localparam logic [RFC_PHASE_W-1:0] PH_CHECK = 3'd4;
  localparam logic [RFC_PHASE_W-1:0] PH_END = 3'd5;

  // verdict codes
  localparam logic [RFC_VERDICT_W-1:0] VERD_OK = 2'd0;
  localparam logic [RFC_VERDICT_W-1:0] VERD_SMALL = 2'd1;
  localparam logic [RFC_VERDICT_W-1:0] VERD_TRUNC = 2'd2;
  localparam logic [RFC_VERDICT_W-1:0] VERD_MISMATCH = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rfc_item_t;

  typedef struct packed {
    logic [RFC_VERDICT_W-1:0] verdict;
    logic [RFC_PASSED_W-1:0]  blocks_passed;
  } rfc_result_t;

  // one byte of reflected crc-32, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ RFC_CRC_POLY) : (v >> 1);
    end
    return (crc >> 8) ^ v;
  endfunction

endpackage

// ===== rtl/rfc_ifs.sv =====
interface rfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rfc_out_if
  import rfc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [RFC_VERDICT_W-1:0] verdict;
  logic [RFC_PASSED_W-1:0]  blocks_passed;

  modport source (output valid, output verdict, output blocks_passed, input ready);
  modport sink (input valid, input verdict, input blocks_passed, output ready);
endinterface

// ===== rtl/crc_framed_record_file_checker_unit.sv =====
// channel   dir  payload                              transfer when
// in_ch     in   data_byte[7:0], last_byte            valid && ready
// out_ch    out  verdict[1:0], blocks_passed[30:0]    valid && ready
// cfg_      in   cfg_wr_data[15:0] (min_file_bytes)   cfg_wr_en
//
// one byte per cycle sustained unless a last byte meets a full result slot
// the crc of a byte (eight shift steps) plus field decode sit between the
// input register and the state/result registers
// rst_n is synchronous, active low; min_file_bytes resets to 100
// a stalled output only holds back a last byte and the bytes queued behind it
module crc_framed_record_file_checker_unit
  import rfc_pkg::*;
#(
  parameter int LENGTH_FIELD_BYTES = RFC_LENGTH_BYTES_DEF,
  parameter int CHECKSUM_FIELD_BYTES = RFC_CHECKSUM_BYTES_DEF,
  parameter int HEADER_WORD_BYTES = RFC_HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rfc_in_if.sink      in_ch,
  rfc_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // min file length register
  logic [15:0] min_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bytes_r <= RFC_MIN_BYTES_RST;
    end else if (cfg_wr_en) begin
      min_bytes_r <= cfg_wr_data;
    end
  end

  // input register stage
  logic        s1_valid;
  rfc_item_t   s1_item;
  logic        s1_take;
  logic        out_space;
  rfc_result_t result;

  rfc_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .take_i  (s1_take),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  // a byte moves on unless it is the last one and the result slot is full
  assign s1_take = s1_valid && (!s1_item.last_byte || out_space);

  // record parser: phases, counters, running crc, verdict
  rfc_parser #(
    .LENGTH_FIELD_BYTES   (LENGTH_FIELD_BYTES),
    .CHECKSUM_FIELD_BYTES (CHECKSUM_FIELD_BYTES),
    .HEADER_WORD_BYTES    (HEADER_WORD_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire_i      (s1_take),
    .item_i      (s1_item),
    .min_bytes_i (min_bytes_r),
    .result_o    (result)
  );

  // result register, loaded only on the last byte of a file
  rfc_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_i   (s1_take && s1_item.last_byte),
    .result_i (result),
    .space_o  (out_space),
    .out_ch   (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !(s1_take && s1_item.last_byte))
    else $error("pending verdict overwritten");
`endif

endmodule

// ===== rtl/rfc_in_reg.sv =====
module rfc_in_reg
  import rfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rfc_in_if.sink    in_ch,
  input  logic      take_i,
  output logic      valid_o,
  output rfc_item_t item_o
);

  logic      valid_r, valid_nxt;
  rfc_item_t item_r;
  logic      accept;

  assign in_ch.ready = !valid_r || take_i;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{data_byte: in_ch.data_byte, last_byte: in_ch.last_byte};
    end
  end

  assign valid_o = valid_r;
  assign item_o = item_r;

endmodule

// ===== rtl/rfc_parser.sv =====
module rfc_parser
  import rfc_pkg::*;
#(
  parameter int LENGTH_FIELD_BYTES = RFC_LENGTH_BYTES_DEF,
  parameter int CHECKSUM_FIELD_BYTES = RFC_CHECKSUM_BYTES_DEF,
  parameter int HEADER_WORD_BYTES = RFC_HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire_i,
  input  rfc_item_t   item_i,
  input  logic [15:0] min_bytes_i,
  output rfc_result_t result_o
);

  localparam int MAX_A = (LENGTH_FIELD_BYTES > CHECKSUM_FIELD_BYTES) ?
                         LENGTH_FIELD_BYTES : CHECKSUM_FIELD_BYTES;
  localparam int MAX_B = (HEADER_WORD_BYTES > RFC_COUNT_BYTES) ?
                         HEADER_WORD_BYTES : RFC_COUNT_BYTES;
  localparam int MAX_F = (MAX_A > MAX_B) ? MAX_A : MAX_B;
  localparam int IDX_W = $clog2(MAX_F + 1);
  localparam int LEN_W = 8 * LENGTH_FIELD_BYTES;
  localparam int CHK_W = 8 * CHECKSUM_FIELD_BYTES;

  logic [RFC_PHASE_W-1:0]  phase_r, phase_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [31:0]             expected_r, expected_nxt;
  logic [RFC_PASSED_W-1:0] done_r, done_nxt;
  logic [LEN_W-1:0]        remain_r, remain_nxt;
  logic [31:0]             crc_r, crc_nxt;
  logic [CHK_W-1:0]        chk_r, chk_nxt;
  logic                    mism_r, mism_nxt;
  logic [15:0]             bytes_r, bytes_nxt;

  // values after consuming the byte, before the end-of-file clear
  logic [RFC_PHASE_W-1:0]  phase_s;
  logic [IDX_W-1:0]        idx_s;
  logic [31:0]             expected_s;
  logic [RFC_PASSED_W-1:0] done_s;
  logic [LEN_W-1:0]        remain_s;
  logic [31:0]             crc_s;
  logic [CHK_W-1:0]        chk_s;
  logic                    mism_s;
  logic [15:0]             bytes_s;

  logic [IDX_W-1:0]        idx_inc;
  logic [31:0]             exp_ins;
  logic [LEN_W-1:0]        len_ins;
  logic [LEN_W-1:0]        len_dec;
  logic [CHK_W-1:0]        chk_ins;
  logic [31:0]             crc_upd;
  logic [RFC_PASSED_W-1:0] done_inc;
  logic [7:0]              b;

  assign b = item_i.data_byte;
  assign idx_inc = idx_r + IDX_W'(1);
  assign crc_upd = crc_byte(crc_r, b);
  assign len_dec = remain_r - LEN_W'(1);
  assign done_inc = done_r + RFC_PASSED_W'(1);

  // byte lane inserts
  always_comb begin
    exp_ins = expected_r;
    len_ins = remain_r;
    chk_ins = chk_r;
    for (int k = 0; k < RFC_COUNT_BYTES; k++) begin
      if (idx_r == IDX_W'(k)) exp_ins[8*k +: 8] = exp_ins[8*k +: 8] | b;
    end
    for (int k = 0; k < LENGTH_FIELD_BYTES; k++) begin
      if (idx_r == IDX_W'(k)) len_ins[8*k +: 8] = len_ins[8*k +: 8] | b;
    end
    for (int k = 0; k < CHECKSUM_FIELD_BYTES; k++) begin
      if (idx_r == IDX_W'(k)) chk_ins[8*k +: 8] = chk_ins[8*k +: 8] | b;
    end
  end

  always_comb begin
    phase_s = phase_r;
    idx_s = idx_r;
    expected_s = expected_r;
    done_s = done_r;
    remain_s = remain_r;
    crc_s = crc_r;
    chk_s = chk_r;
    mism_s = mism_r;
    bytes_s = (bytes_r == 16'hFFFF) ? bytes_r : bytes_r + 16'd1;
    case (phase_r)
      PH_HEADER: begin
        if (idx_inc >= IDX_W'(HEADER_WORD_BYTES)) begin
          phase_s = PH_COUNT;
          idx_s = '0;
        end else begin
          idx_s = idx_inc;
        end
      end
      PH_COUNT: begin
        expected_s = exp_ins;
        idx_s = idx_inc;
        if (idx_inc >= IDX_W'(RFC_COUNT_BYTES)) begin
          if (exp_ins == 32'd0 || exp_ins[31]) begin
            phase_s = PH_END;
          end else begin
            phase_s = PH_LENGTH;
            idx_s = '0;
            remain_s = '0;
            crc_s = '0;
            chk_s = '0;
          end
        end
      end
      PH_LENGTH: begin
        remain_s = len_ins;
        crc_s = crc_upd;
        idx_s = idx_inc;
        if (idx_inc >= IDX_W'(LENGTH_FIELD_BYTES)) begin
          idx_s = '0;
          phase_s = (len_ins == '0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_s = crc_upd;
        remain_s = len_dec;
        if (len_dec == '0) begin
          phase_s = PH_CHECK;
          idx_s = '0;
        end
      end
      PH_CHECK: begin
        chk_s = chk_ins;
        idx_s = idx_inc;
        if (idx_inc >= IDX_W'(CHECKSUM_FIELD_BYTES)) begin
          if (chk_ins == CHK_W'(crc_r)) begin
            done_s = done_inc;
            if ({1'b0, done_inc} >= expected_r) begin
              phase_s = PH_END;
            end else begin
              phase_s = PH_LENGTH;
              idx_s = '0;
              remain_s = '0;
              crc_s = '0;
              chk_s = '0;
            end
          end else begin
            mism_s = 1'b1;
            phase_s = PH_END;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // verdict from the post-byte state
  always_comb begin
    result_o.blocks_passed = done_s;
    if (bytes_s < min_bytes_i) begin
      result_o.verdict = VERD_SMALL;
      result_o.blocks_passed = '0;
    end else if (mism_s) begin
      result_o.verdict = VERD_MISMATCH;
    end else if (phase_s != PH_END) begin
      result_o.verdict = VERD_TRUNC;
    end else begin
      result_o.verdict = VERD_OK;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt = idx_r;
    expected_nxt = expected_r;
    done_nxt = done_r;
    remain_nxt = remain_r;
    crc_nxt = crc_r;
    chk_nxt = chk_r;
    mism_nxt = mism_r;
    bytes_nxt = bytes_r;
    if (fire_i) begin
      if (item_i.last_byte) begin
        phase_nxt = PH_HEADER;
        idx_nxt = '0;
        expected_nxt = '0;
        done_nxt = '0;
        remain_nxt = '0;
        crc_nxt = '0;
        chk_nxt = '0;
        mism_nxt = 1'b0;
        bytes_nxt = '0;
      end else begin
        phase_nxt = phase_s;
        idx_nxt = idx_s;
        expected_nxt = expected_s;
        done_nxt = done_s;
        remain_nxt = remain_s;
        crc_nxt = crc_s;
        chk_nxt = chk_s;
        mism_nxt = mism_s;
        bytes_nxt = bytes_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      idx_r <= '0;
      expected_r <= '0;
      done_r <= '0;
      remain_r <= '0;
      crc_r <= '0;
      chk_r <= '0;
      mism_r <= 1'b0;
      bytes_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r <= idx_nxt;
      expected_r <= expected_nxt;
      done_r <= done_nxt;
      remain_r <= remain_nxt;
      crc_r <= crc_nxt;
      chk_r <= chk_nxt;
      mism_r <= mism_nxt;
      bytes_r <= bytes_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && item_i.last_byte |=> phase_r == PH_HEADER && bytes_r == 16'd0 && !mism_r)
    else $error("state not cleared after last byte");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> remain_r != '0)
    else $error("data phase with zero bytes left");

  a_done_below_expected: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LENGTH || phase_r == PH_DATA || phase_r == PH_CHECK)
      |-> {1'b0, done_r} < expected_r)
    else $error("block in progress past expected count");

  a_mismatch_ends: assert property (@(posedge clk) disable iff (!rst_n)
    mism_r |-> phase_r == PH_END)
    else $error("mismatch recorded outside end phase");
`endif

endmodule

// ===== rtl/rfc_out_reg.sv =====
module rfc_out_reg
  import rfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load_i,
  input  rfc_result_t result_i,
  output logic        space_o,
  rfc_out_if.source   out_ch
);

  logic        valid_r, valid_nxt;
  rfc_result_t result_r;

  assign space_o = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      result_r <= result_i;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.verdict = result_r.verdict;
  assign out_ch.blocks_passed = result_r.blocks_passed;

endmodule
